// ===== hw/rtl/kgno_pkg.sv =====
// shared types, constants and helpers for the neighbour overlap core
package kgno_pkg;

    localparam int MAX_NODES     = 64;
    localparam int MAX_NEIGHBORS = 63;
    localparam int SIM_BITS      = 32;
    localparam int FRAC_BITS     = 16;
    localparam int IDX_BITS      = $clog2(MAX_NODES);
    localparam int CNT_BITS      = $clog2(MAX_NODES + 1);
    localparam int K_BITS        = $clog2(MAX_NEIGHBORS + 1);
    localparam int OUT_BITS      = 22;
    localparam int NUM_BITS      = K_BITS + FRAC_BITS;
    localparam int DEN_BITS      = K_BITS + 1;
    localparam int ADDR_BITS     = 4;

    typedef enum logic [1:0] {
        REG_NODE_COUNT  = 2'd0,
        REG_NEIGHBOR    = 2'd1,
        REG_SELECT      = 2'd2,
        REG_MEASURE     = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        MODE_SHARED   = 3'd0,
        MODE_JACCARD  = 3'd1,
        MODE_SORENSEN = 3'd2,
        MODE_HUB      = 3'd3,
        MODE_RA       = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_COUNT  = 2'd1,
        ST_DIVIDE = 2'd2,
        ST_OUT    = 2'd3
    } t_state;

    // one link of the sorted chain
    typedef struct packed {
        logic                vld;
        logic [SIM_BITS-1:0] key;
        logic [IDX_BITS-1:0] col;
    } t_entry;

    // control broadcast to every cell
    typedef struct packed {
        logic                ins;
        logic                clr;
        logic                largest;
        logic [K_BITS-1:0]   k;
        logic [SIM_BITS-1:0] key;
        logic [IDX_BITS-1:0] col;
    } t_cell_ctl;

    function automatic logic [SIM_BITS-1:0] sim_key(input logic [SIM_BITS-1:0] v);
        sim_key = {~v[SIM_BITS-1], v[SIM_BITS-2:0]};
    endfunction

endpackage

// ===== hw/rtl/kgno_if.sv =====
// valid/ready channel with payload
interface kgno_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/kgno_ram.sv =====
// generic simple dual-port ram with registered read
module kgno_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hw/rtl/kgno_cell.sv =====
// one position of the sorted top-k chain
module kgno_cell import kgno_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [K_BITS-1:0] i_pos,
    input  t_cell_ctl         i_ctl,
    input  t_entry            i_prev,
    input  logic              i_prev_take,
    output t_entry            o_entry,
    output logic              o_take
);
    t_entry r_e;
    t_entry n_e;
    logic   better;
    logic   in_k;

    assign in_k   = {1'b0, i_pos} < {1'b0, i_ctl.k};
    assign better = i_ctl.largest ? (i_ctl.key > r_e.key) : (i_ctl.key < r_e.key);
    // key lands here or further up the chain
    assign o_take = i_prev_take || !r_e.vld || better;

    always_comb begin
        n_e = r_e;
        if (i_ctl.clr) begin
            n_e.vld = 1'b0;
        end else if (i_ctl.ins && !in_k) begin
            // positions past k drop out once the chain is used with a smaller k
            n_e.vld = 1'b0;
        end else if (i_ctl.ins && in_k && o_take) begin
            if (i_prev_take) begin
                n_e = i_prev;
            end else begin
                n_e.vld = 1'b1;
                n_e.key = i_ctl.key;
                n_e.col = i_ctl.col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.vld <= 1'b0;
        end else begin
            r_e.vld <= n_e.vld;
        end
        r_e.key <= n_e.key;
        r_e.col <= n_e.col;
    end

    assign o_entry = r_e;
endmodule

// ===== hw/rtl/kgno_chain.sv =====
// row of cells holding the best columns of the current row
module kgno_chain import kgno_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cell_ctl            i_ctl,
    output logic [MAX_NODES-1:0] o_set
);
    t_entry ent  [MAX_NEIGHBORS];
    logic   take [MAX_NEIGHBORS];

    for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
        t_entry p;
        logic   pt;
        if (g == 0) begin : g_head
            assign p  = '0;
            assign pt = 1'b0;
        end else begin : g_link
            assign p  = ent[g-1];
            assign pt = take[g-1];
        end
        kgno_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_pos       (K_BITS'(g)),
            .i_ctl       (i_ctl),
            .i_prev      (p),
            .i_prev_take (pt),
            .o_entry     (ent[g]),
            .o_take      (take[g])
        );
    end

    always_comb begin
        o_set = '0;
        for (int e = 0; e < MAX_NEIGHBORS; e++) begin
            if (ent[e].vld && (e < int'(i_ctl.k))) begin
                o_set[ent[e].col] = 1'b1;
            end
        end
    end
endmodule

// ===== hw/rtl/knn_graph_neighbour_overlap_core.sv =====
// top level of the shared nearest neighbour similarity core
// Each load is accepted and then inserted into the chain of 63 cells, with
// ready held low meanwhile; a row's last column also holds ready low while
// its neighbour set is written to the row RAM. A query that divides goes
// through two RAM reads, a popcount, a 22-step restoring divider one quotient
// bit per cycle and an output register; other queries skip the divider. A
// stalled result holds the core until it is taken. Results come only from
// queries. No clearing pass is needed.
module knn_graph_neighbour_overlap_core import kgno_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    kgno_if.sink                 i_req,
    kgno_if.source               o_rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    logic [6:0] r_nodes;
    logic [5:0] r_k;
    logic       r_largest;
    logic [2:0] r_mode;
    t_reg_idx   widx;

    assign pready = 1'b1;
    assign widx   = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes <= 7'd64; r_k <= 6'd8; r_largest <= 1'b1; r_mode <= MODE_SHARED;
        end else if (psel && penable && pwrite) begin
            case (widx)
                REG_NODE_COUNT: r_nodes   <= pwdata[6:0];
                REG_NEIGHBOR:   r_k       <= pwdata[5:0];
                REG_SELECT:     r_largest <= pwdata[0];
                REG_MEASURE:    r_mode    <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (widx)
            REG_NODE_COUNT: prdata = {25'd0, r_nodes};
            REG_NEIGHBOR:   prdata = {26'd0, r_k};
            REG_SELECT:     prdata = {31'd0, r_largest};
            REG_MEASURE:    prdata = {29'd0, r_mode};
            default:        prdata = '0;
        endcase
    end

    // effective n and k
    logic [CNT_BITS-1:0] n_eff;
    logic [K_BITS-1:0]   k_eff;
    logic [CNT_BITS-1:0] k_lim;
    always_comb begin
        n_eff = (r_nodes < 7'd2) ? CNT_BITS'(2) :
                (r_nodes > 7'(MAX_NODES)) ? CNT_BITS'(MAX_NODES) : CNT_BITS'(r_nodes);
        k_lim = n_eff - 1'b1;
        if (k_lim > CNT_BITS'(MAX_NEIGHBORS)) k_lim = CNT_BITS'(MAX_NEIGHBORS);
        k_eff = ({1'b0, r_k} > k_lim) ? K_BITS'(k_lim) : r_k;
        if (k_eff == '0) k_eff = K_BITS'(1);
    end

    // request fields
    logic                 q_type;
    logic [IDX_BITS-1:0]  q_row, q_col;
    logic [SIM_BITS-1:0]  q_sim;
    assign {q_type, q_row, q_col, q_sim} = i_req.data;

    t_state               r_st, n_st;
    logic                 r_ld;
    logic [IDX_BITS-1:0]  r_row, r_col;
    logic [SIM_BITS-1:0]  r_key;
    logic                 r_err;
    logic [MAX_NODES-1:0] r_loaded;
    logic [MAX_NODES-1:0] r_a;
    logic                 r_rd2;
    logic [4:0]           r_step;
    logic [NUM_BITS+6-1:0] r_rem;
    logic [OUT_BITS-1:0]  r_quo;
    logic [DEN_BITS-1:0]  r_den;
    logic                 r_div;
    logic [OUT_BITS-1:0]  r_out;
    logic                 r_oerr;
    logic                 r_ovld;

    logic                 acc;
    logic                 fin_d;
    assign i_req.ready = (r_st == ST_IDLE) && !r_ld && !fin_d;
    assign acc         = i_req.valid && i_req.ready;

    // chain control; each accepted load is inserted via r_ld, and no new request is taken until it is in
    t_cell_ctl            ctl;
    logic [MAX_NODES-1:0] set;
    logic                 ld_ok, last;
    assign ld_ok = ({1'b0, r_row} < n_eff) && ({1'b0, r_col} < n_eff) && (r_row != r_col);
    assign last  = ({1'b0, r_row} == n_eff - 1'b1) ?
                   ({1'b0, r_col} == n_eff - 2'd2) : ({1'b0, r_col} == n_eff - 1'b1);

    logic [IDX_BITS-1:0] fin_row;
    always_comb begin
        ctl.ins     = r_ld && ld_ok;
        ctl.clr     = fin_d;
        ctl.largest = r_largest;
        ctl.k       = k_eff;
        ctl.key     = r_key;
        ctl.col     = r_col;
    end

    kgno_chain u_chain (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_set(set));

    // set RAM written the cycle after the last insertion
    logic                 we;
    logic [IDX_BITS-1:0]  raddr;
    logic [MAX_NODES-1:0] rdata;
    assign we = fin_d;
    kgno_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(fin_row), .i_wdata(set),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            fin_d <= 1'b0;
        end else begin
            fin_d <= r_ld && ld_ok && last;
        end
        fin_row <= r_row;
    end

    // popcount of the shared neighbours below n
    logic [CNT_BITS-1:0] pc;
    logic [MAX_NODES-1:0] nmask;
    always_comb begin
        nmask = '0;
        for (int b = 0; b < MAX_NODES; b++) nmask[b] = (CNT_BITS'(b) < n_eff);
        pc = '0;
        for (int b = 0; b < MAX_NODES; b++) pc = pc + CNT_BITS'(r_a[b] & rdata[b] & nmask[b]);
    end

    logic [K_BITS-1:0]   cl;
    logic [DEN_BITS-1:0] den;
    always_comb begin
        cl = (pc > CNT_BITS'(k_eff)) ? k_eff : K_BITS'(pc);
        case (r_mode)
            MODE_JACCARD:  den = {k_eff, 1'b0} - DEN_BITS'(cl);
            MODE_SORENSEN: den = {k_eff, 1'b0};
            default:       den = {1'b0, k_eff};
        endcase
    end

    // first row is read at the transfer edge, second row in the next cycle
    assign raddr = (r_st == ST_IDLE) ? q_row : r_col;

    logic [NUM_BITS+6-1:0] rem_sh;
    logic [OUT_BITS-1:0]   div_top;
    assign div_top = r_quo;
    assign rem_sh  = {r_rem[NUM_BITS+4:0], div_top[OUT_BITS-1]};

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:   if (acc && q_type) n_st = ST_COUNT;
            ST_COUNT:  if (r_rd2) n_st = ST_DIVIDE;
            ST_DIVIDE: if (!r_div || r_step == 5'd0) n_st = ST_OUT;
            ST_OUT:    if (!r_ovld || o_rsp.ready) n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_ld <= 1'b0; r_loaded <= '0; r_ovld <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ld <= acc && !q_type;
            if (fin_d) r_loaded[fin_row] <= 1'b1;
            if (r_st == ST_OUT && n_st == ST_IDLE) r_ovld <= 1'b1;
            else if (o_rsp.ready) r_ovld <= 1'b0;
        end
    end

    // query datapath: read row a, then row b, then count, then divide where the measure needs it
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_row <= q_row; r_col <= q_col; r_key <= sim_key(q_sim);
            r_rd2 <= 1'b0;
            r_err <= ({1'b0, q_row} >= n_eff) || ({1'b0, q_col} >= n_eff) ||
                     !r_loaded[q_row] || !r_loaded[q_col];
        end
        if (r_st == ST_COUNT) begin
            r_rd2 <= 1'b1;
            if (!r_rd2) r_a <= rdata;
            else begin
                r_quo  <= '0;
                r_step <= 5'(OUT_BITS - 1);
                r_den  <= den;
                r_div  <= 1'b0;
                r_rem  <= '0;
                if (r_err || r_mode > MODE_RA) begin
                    r_quo <= '0;
                end else if (r_row == r_col) begin
                    r_quo <= (r_mode == MODE_SHARED || r_mode == MODE_RA) ?
                             OUT_BITS'({k_eff, FRAC_BITS'(0)}) : OUT_BITS'(1 << FRAC_BITS);
                end else if (r_mode == MODE_SHARED) begin
                    r_quo <= OUT_BITS'({pc, FRAC_BITS'(0)});
                end else begin
                    r_div <= 1'b1;
                    r_quo <= OUT_BITS'({cl, FRAC_BITS'(0)});
                end
            end
        end
        if (r_st == ST_DIVIDE && r_div) begin
            // restoring division: dividend shifts out of r_quo into r_rem
            if (rem_sh >= (NUM_BITS+6)'(r_den)) begin
                r_rem <= rem_sh - (NUM_BITS+6)'(r_den);
                r_quo <= {div_top[OUT_BITS-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {div_top[OUT_BITS-2:0], 1'b0};
            end
            r_step <= r_step - 1'b1;
        end
        if (r_st == ST_OUT && n_st == ST_IDLE) begin
            r_out  <= r_quo;
            r_oerr <= r_err;
        end
    end

    assign o_rsp.valid = r_ovld;
    assign o_rsp.data  = {r_out, r_oerr};

`ifndef SYNTH
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != ST_IDLE) |-> !i_req.ready) else $error("ready while busy");
    a_fin_after_ld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_d |-> $past(r_ld)) else $error("row finish without load");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && r_oerr) |-> (r_out == '0)) else $error("error with value");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_OUT && r_ovld && !o_rsp.ready) |=> r_ovld) else $error("result lost");
`endif
endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the shared nearest neighbour similarity core
module testbench;
    import kgno_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQ_W      = 1 + 2 * IDX_BITS + SIM_BITS;
    localparam int RSP_W      = OUT_BITS + 1;
    localparam int ITEM_GOAL  = 1350;
    localparam int SETTLE     = 40;
    localparam int WDOG_LIMIT = 6000;
    localparam int PRESS_LEN  = 400;
    localparam bit REQ_LOAD   = 1'b0;
    localparam bit REQ_QUERY  = 1'b1;

    typedef struct {
        bit                q;
        bit [IDX_BITS-1:0] r;
        bit [IDX_BITS-1:0] c;
        bit [SIM_BITS-1:0] s;
    } t_item;

    typedef struct {
        t_item              it;
        bit                 typed;
        bit [OUT_BITS-1:0]  m;
        bit                 e;
    } t_row;

    typedef struct {
        bit [OUT_BITS-1:0] m;
        bit                e;
    } t_measure;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0] pwdata, prdata;

    kgno_if #(.W(REQ_W)) req_bus ();
    kgno_if #(.W(RSP_W)) rsp_bus ();

    knn_graph_neighbour_overlap_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow state of the core
    bit [MAX_NODES-1:0] nbr_sets [MAX_NODES];
    bit [MAX_NODES-1:0] rows_done;
    bit [SIM_BITS-1:0]  chain_key [MAX_NEIGHBORS];
    bit [IDX_BITS-1:0]  chain_col [MAX_NEIGHBORS];
    int unsigned        chain_fill;
    bit [6:0]           cfg_nodes;
    bit [5:0]           cfg_k;
    bit                 cfg_largest;
    bit [2:0]           cfg_mode;

    t_measure pending_measures [$];
    int       failures;
    int       items_sent;
    int       measures_seen;
    int       error_replies;
    int       phases;
    int       idle_cycles;
    bit       calm;
    bit       pressure_done;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    function automatic int unsigned nodes_eff();
        int unsigned n;
        n = cfg_nodes;
        if (n < 2) n = 2;
        if (n > MAX_NODES) n = MAX_NODES;
        return n;
    endfunction

    function automatic int unsigned k_eff();
        int unsigned lim, k;
        lim = nodes_eff() - 1;
        if (lim > MAX_NEIGHBORS) lim = MAX_NEIGHBORS;
        k = cfg_k;
        if (k > lim) k = lim;
        if (k < 1) k = 1;
        return k;
    endfunction

    function automatic bit ranks_higher(bit [SIM_BITS-1:0] a, bit [SIM_BITS-1:0] b);
        return cfg_largest ? (a > b) : (a < b);
    endfunction

    function automatic void absorb_entry(bit [IDX_BITS-1:0] row, bit [IDX_BITS-1:0] col,
                                         bit [SIM_BITS-1:0] sim);
        int unsigned n, k, fill, p, last, lastcol;
        bit [SIM_BITS-1:0] key;
        bit [MAX_NODES-1:0] set;
        n = nodes_eff();
        k = k_eff();
        if (row >= n || col >= n || row == col) return;
        key = {~sim[SIM_BITS-1], sim[SIM_BITS-2:0]};
        fill = chain_fill < k ? chain_fill : k;
        p = 0;
        while (p < fill && !ranks_higher(key, chain_key[p])) p++;
        if (p >= k) begin
            chain_fill = fill;
        end else begin
            last = fill < k ? fill : k - 1;
            while (last > p) begin
                chain_key[last] = chain_key[last-1];
                chain_col[last] = chain_col[last-1];
                last--;
            end
            chain_key[p] = key;
            chain_col[p] = col;
            chain_fill = fill < k ? fill + 1 : k;
        end
        lastcol = (row == n - 1) ? n - 2 : n - 1;
        if (col == lastcol) begin
            fill = chain_fill < k ? chain_fill : k;
            set = '0;
            for (int e = 0; e < fill; e++) set[chain_col[e]] = 1'b1;
            nbr_sets[row] = set;
            rows_done[row] = 1'b1;
            chain_fill = 0;
        end
    endfunction

    function automatic t_measure overlap_measure(bit [IDX_BITS-1:0] a, bit [IDX_BITS-1:0] b);
        t_measure res;
        int unsigned n, k, c;
        bit [MAX_NODES-1:0] mask, both;
        longint unsigned num, value;
        n = nodes_eff();
        k = k_eff();
        res.m = '0;
        res.e = 1'b0;
        value = 0;
        if (a >= n || b >= n || !rows_done[a] || !rows_done[b]) begin
            res.e = 1'b1;
            return res;
        end
        if (a == b) begin
            if (cfg_mode == MODE_SHARED || cfg_mode == MODE_RA) value = longint'(k) << FRAC_BITS;
            else if (cfg_mode <= MODE_HUB) value = 64'd1 << FRAC_BITS;
        end else begin
            mask = (n >= MAX_NODES) ? '1 : ((64'd1 << n) - 1);
            both = nbr_sets[a] & nbr_sets[b] & mask;
            c = $countones(both);
            if (cfg_mode == MODE_SHARED) begin
                value = longint'(c) << FRAC_BITS;
            end else begin
                if (c > k) c = k;
                num = longint'(c) << FRAC_BITS;
                case (cfg_mode)
                    MODE_JACCARD:  value = num / (2 * k - c);
                    MODE_SORENSEN: value = num / (2 * k);
                    MODE_HUB,
                    MODE_RA:       value = num / k;
                    default:       value = 0;
                endcase
            end
        end
        res.m = value[OUT_BITS-1:0];
        return res;
    endfunction

    task automatic write_reg(t_reg_idx idx, bit [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(4 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        idle_cycles = 0;
        case (idx)
            REG_NODE_COUNT: cfg_nodes   = value[6:0];
            REG_NEIGHBOR:   cfg_k       = value[5:0];
            REG_SELECT:     cfg_largest = value[0];
            REG_MEASURE:    cfg_mode    = value[2:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (pending_measures.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(bit [6:0] n, bit [5:0] k, bit sel, bit [2:0] mode);
        drain();
        write_reg(REG_NODE_COUNT, 32'(n));
        write_reg(REG_NEIGHBOR, 32'(k));
        write_reg(REG_SELECT, 32'(sel));
        write_reg(REG_MEASURE, 32'(mode));
    endtask

    task automatic offer(t_item it, bit typed, bit [OUT_BITS-1:0] m, bit e);
        int gap;
        t_measure res;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data  <= {it.q, it.r, it.c, it.s};
        do @(posedge i_clk); while (!req_bus.ready);
        idle_cycles = 0;
        items_sent++;
        if (it.q == REQ_QUERY) begin
            if (typed) begin
                res.m = m;
                res.e = e;
            end else begin
                res = overlap_measure(it.r, it.c);
            end
            pending_measures.push_back(res);
        end else begin
            absorb_entry(it.r, it.c, it.s);
        end
    endtask

    task automatic send(bit q, int r, int c, bit [31:0] s);
        t_item it;
        it.q = q;
        it.r = IDX_BITS'(r);
        it.c = IDX_BITS'(c);
        it.s = s;
        offer(it, 1'b0, '0, 1'b0);
    endtask

    task automatic random_phase();
        int unsigned n, rows;
        bit [6:0] nc;
        bit [5:0] kc;
        bit ties;
        n = $urandom_range(0, 9);
        nc = (n < 2) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(2, 10));
        kc = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 6));
        configure(nc, kc, 1'($urandom), 3'($urandom_range(0, 7)));
        calm = (phases % 4 == 1);
        n = nodes_eff();
        rows = (n > 16) ? 3 : n;
        ties = $urandom_range(0, 1);
        for (int i = 0; i < rows; i++) begin
            int r;
            r = (rows == n) ? i : $urandom_range(0, n - 1);
            for (int c = 0; c < n; c++) begin
                if (c == r) continue;
                if ($urandom_range(0, 29) == 0) continue;
                if ($urandom_range(0, 9) == 0)
                    send(1'($urandom), $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
                send(REQ_LOAD, r, c, ties ? 32'($urandom_range(0, 3)) : 32'($urandom));
            end
        end
        for (int i = 0; i < 2 * n + 4; i++) begin
            if ($urandom_range(0, 7) == 0)
                send(REQ_QUERY, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
            else
                send(REQ_QUERY, $urandom_range(0, n - 1), $urandom_range(0, n - 1), $urandom);
        end
        phases++;
    endtask

    t_row directed [] = '{
        '{'{REQ_QUERY, 6'd0,  6'd0,  32'h0},        1'b1, 22'd0,      1'b1},
        '{'{REQ_QUERY, 6'd63, 6'd62, 32'h0},        1'b1, 22'd0,      1'b1},
        '{'{REQ_LOAD,  6'd7,  6'd7,  32'h1234},     1'b0, 22'd0,      1'b0},
        '{'{REQ_LOAD,  6'd0,  6'd1,  32'h7FFFFFFF}, 1'b0, 22'd0,      1'b0},
        '{'{REQ_LOAD,  6'd0,  6'd2,  32'h80000000}, 1'b0, 22'd0,      1'b0},
        '{'{REQ_LOAD,  6'd0,  6'd3,  32'h0},        1'b0, 22'd0,      1'b0},
        '{'{REQ_LOAD,  6'd0,  6'd4,  32'h0},        1'b0, 22'd0,      1'b0},
        '{'{REQ_QUERY, 6'd0,  6'd1,  32'hFFFFFFFF}, 1'b1, 22'd0,      1'b1},
        '{'{REQ_LOAD,  6'd0,  6'd63, 32'h5},        1'b0, 22'd0,      1'b0},
        '{'{REQ_LOAD,  6'd5,  6'd63, 32'h1},        1'b0, 22'd0,      1'b0},
        '{'{REQ_QUERY, 6'd0,  6'd0,  32'h0},        1'b1, 22'd524288, 1'b0},
        '{'{REQ_QUERY, 6'd0,  6'd5,  32'h0},        1'b0, 22'd0,      1'b0},
        '{'{REQ_QUERY, 6'd5,  6'd0,  32'h0},        1'b0, 22'd0,      1'b0},
        '{'{REQ_QUERY, 6'd63, 6'd0,  32'h0},        1'b1, 22'd0,      1'b1},
        '{'{REQ_LOAD,  6'd63, 6'd62, 32'hFFFFFFFF}, 1'b0, 22'd0,      1'b0},
        '{'{REQ_QUERY, 6'd63, 6'd63, 32'h0},        1'b1, 22'd524288, 1'b0},
        '{'{REQ_QUERY, 6'd0,  6'd63, 32'h0},        1'b0, 22'd0,      1'b0}
    };

    // result side: random stalls plus one long hold-off
    initial begin
        int gap;
        t_measure got, want;
        rsp_bus.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 19);
            if (!pressure_done && measures_seen == 10) begin
                gap = PRESS_LEN;
                pressure_done = 1'b1;
            end
            if (gap != 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!(rsp_bus.valid && rsp_bus.ready));
            idle_cycles = 0;
            measures_seen++;
            {got.m, got.e} = rsp_bus.data;
            if (got.e) error_replies++;
            if (pending_measures.size() == 0) begin
                $error("unexpected transfer: measure_value %0d query_error %0d", got.m, got.e);
                failures++;
            end else begin
                want = pending_measures.pop_front();
                if (got.m !== want.m) begin
                    $error("measure_value expected %0d actual %0d", want.m, got.m);
                    failures++;
                end
                if (got.e !== want.e) begin
                    $error("query_error expected %0d actual %0d", want.e, got.e);
                    failures++;
                end
            end
        end
    end

    // no transfer for too long means the core hung
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("timeout with %0d measures outstanding", pending_measures.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        req_bus.valid <= 1'b0;
        req_bus.data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        failures = 0;
        items_sent = 0;
        measures_seen = 0;
        error_replies = 0;
        phases = 0;
        calm = 1'b0;
        pressure_done = 1'b0;
        rows_done = '0;
        chain_fill = 0;
        foreach (nbr_sets[i]) nbr_sets[i] = '0;
        cfg_nodes = 7'd64;
        cfg_k = 6'd8;
        cfg_largest = 1'b1;
        cfg_mode = MODE_SHARED;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[i]) offer(directed[i].it, directed[i].typed, directed[i].m, directed[i].e);
        configure(7'd3,   6'd1,  1'b1, MODE_SHARED);
        configure(7'd2,   6'd0,  1'b0, MODE_JACCARD);
        configure(7'd0,   6'd63, 1'b1, MODE_SORENSEN);
        configure(7'd127, 6'd63, 1'b0, MODE_HUB);
        for (int i = 0; i < 4; i++) begin
            random_phase();
        end
        configure(7'd64, 6'd63, 1'b1, MODE_RA);
        calm = 1'b0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 64; c++)
                if (c != r) send(REQ_LOAD, r, c, $urandom);
        for (int i = 0; i < 12; i++)
            send(REQ_QUERY, $urandom_range(0, 3), $urandom_range(0, 3), $urandom);
        configure(7'd5, 6'd2, 1'b1, 3'd7);
        while (items_sent < ITEM_GOAL) random_phase();
        drain();
        $display("%0d items over %0d random phases, %0d measures checked (%0d error replies)",
                 items_sent, phases, measures_seen, error_replies);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/kgno_pkg.sv
hw/rtl/kgno_if.sv
hw/rtl/kgno_ram.sv
hw/rtl/kgno_cell.sv
hw/rtl/kgno_chain.sv
hw/rtl/knn_graph_neighbour_overlap_core.sv
verif/testbench.sv
